// File: sv/fpn_pkg.sv
// shared constants, permutation rom and arithmetic helpers for fractal_perlin_noise
// depends on nothing; imported by the top level
package fpn_pkg;

    localparam int MAX_OCTAVES     = 16;
    localparam int COORD_FRAC_BITS = 8;
    localparam int INNER_FRAC_BITS = 16;

    localparam int COORD_W   = 24;
    localparam int OCT_W     = $clog2(MAX_OCTAVES);
    localparam int COUNT_W   = 5;
    localparam int SPAN_W    = 16;
    localparam int DECAY_W   = 16;
    localparam int AMP_W     = 17;
    localparam int SUM_W     = 20;
    localparam int FRAC_W    = INNER_FRAC_BITS;
    localparam int QCOORD_W  = 8 + INNER_FRAC_BITS;

    // whole quotient floor(c * 2^TOP_SHIFT / span); octave o takes a window of it
    localparam int TOP_SHIFT   = MAX_OCTAVES + INNER_FRAC_BITS - COORD_FRAC_BITS;
    localparam int QUOT_W      = QCOORD_W + MAX_OCTAVES - 1;
    localparam int DIV_BITS    = COORD_W + TOP_SHIFT;
    localparam int DIV_STEP    = 3;
    localparam int DIV_CYCLES  = DIV_BITS / DIV_STEP;
    localparam int DIV_CNT_W   = $clog2(DIV_CYCLES);

    localparam logic [AMP_W-1:0] AMP_ONE  = AMP_W'(1 << 16);
    localparam logic [15:0]      MAP_MAX  = 16'd65280;
    localparam logic [SUM_W-1:0] SUM_MAX  = 20'd1044480;

    localparam logic [1:0] CFG_OCTAVE_COUNT = 2'd0;
    localparam logic [1:0] CFG_GRID_SPAN    = 2'd1;
    localparam logic [1:0] CFG_AMP_DECAY    = 2'd2;

    localparam logic [COUNT_W-1:0] OCTAVE_COUNT_RST = 5'd8;
    localparam logic [SPAN_W-1:0]  GRID_SPAN_RST    = 16'd200;
    localparam logic [DECAY_W-1:0] AMP_DECAY_RST    = 16'd32768;

    localparam logic [7:0] PERM_ROM [256] = '{
        8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
        8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
        8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,
        8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
        8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,
        8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
        8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,
        8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
        8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,
        8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
        8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,
        8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
        8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,
        8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
        8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,
        8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
        8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,
        8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
        8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,
        8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
        8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,
        8'd215,8'd61,8'd156,8'd180
    };

    // three restoring division steps: {remainder, three quotient bits}
    function automatic logic [SPAN_W+DIV_STEP-1:0] div_step3(
        input logic [SPAN_W-1:0]   rem,
        input logic [DIV_STEP-1:0] bits,
        input logic [SPAN_W-1:0]   den
    );
        logic [SPAN_W:0]       r;
        logic [SPAN_W-1:0]     rr;
        logic [DIV_STEP-1:0]   q;
        rr = rem;
        q  = '0;
        for (int k = DIV_STEP - 1; k >= 0; k--) begin
            r = {rr, bits[k]};
            if (r >= {1'b0, den}) begin
                r    = r - {1'b0, den};
                q[k] = 1'b1;
            end
            rr = r[SPAN_W-1:0];
        end
        return {rr, q};
    endfunction

    // inner fade term t*(6t-15) + 10, Q0.16 in, unsigned 21-bit out
    function automatic logic [20:0] fade_inner(input logic [FRAC_W-1:0] t);
        logic signed [21:0] lin;
        logic signed [38:0] prod;
        logic signed [23:0] acc;
        lin  = $signed({6'd0, t}) * 22'sd6 - 22'sd983040;
        prod = 39'($signed({1'b0, t})) * 39'(lin);
        acc  = 24'(prod >>> FRAC_W) + 24'sd655360;
        return acc[20:0];
    endfunction

    // gradient of the 12-direction set
    function automatic logic signed [18:0] grad(
        input logic [3:0]         h,
        input logic signed [17:0] px,
        input logic signed [17:0] py
    );
        logic signed [18:0] u;
        logic signed [18:0] v;
        u = (h < 4'd8) ? 19'(px) : 19'(py);
        if (h < 4'd4) begin
            v = 19'(py);
        end else if (h == 4'd12 || h == 4'd14) begin
            v = 19'(px);
        end else begin
            v = '0;
        end
        return (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

endpackage

// File: sv/fractal_perlin_noise.sv
// fractal_perlin_noise top level: divider front end, octave sequencer, noise pipeline
// depends on fpn_pkg
//
// Each item carries an x/z map coordinate pair (Q16.8) and yields one noise_sum (Q12.8):
// the amplitude-weighted sum over octave_count octaves of improved perlin noise,
// each octave mapped to 0..255. Items are handled one at a time. After acceptance
// both coordinates go through a shared-step restoring divider by grid_span that
// retires three quotient bits per cycle; the octave coordinates are
// windows of that one quotient. The sequencer then issues one octave per cycle into
// a 7-stage noise pipeline (hash rom lookups, fade products, gradients, two lerp
// levels, mapping, amplitude weight) and an accumulator sums the terms. Once the
// pipeline has drained and the output register is free, the result is loaded and
// the block returns to idle to take the next item. The result sits in an output
// register, so the next item can be accepted while a result waits on m_tready.
// Configuration is written through cfg_wr_en/cfg_index/cfg_wdata; indexes above 2
// are ignored. A grid_span of 0 acts as 1, an octave_count above 16 as 16.
module fractal_perlin_noise
    import fpn_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [23:0] x_coord, [47:24] z_coord
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [19:0] noise_sum, [23:20] zero
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_ISSUE,
        ST_DRAIN
    } state_t;

    // configuration registers
    logic [COUNT_W-1:0] octave_count_reg;
    logic [SPAN_W-1:0]  grid_span_reg;
    logic [DECAY_W-1:0] amp_decay_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            octave_count_reg <= OCTAVE_COUNT_RST;
            grid_span_reg    <= GRID_SPAN_RST;
            amp_decay_reg    <= AMP_DECAY_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_OCTAVE_COUNT: octave_count_reg <= cfg_wdata[COUNT_W-1:0];
                CFG_GRID_SPAN:    grid_span_reg    <= cfg_wdata;
                CFG_AMP_DECAY:    amp_decay_reg    <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    // effective span and octave count
    logic [SPAN_W-1:0]  span_eff;
    logic [COUNT_W-1:0] count_eff;
    assign span_eff  = (grid_span_reg == '0) ? SPAN_W'(1) : grid_span_reg;
    assign count_eff = (octave_count_reg > COUNT_W'(MAX_OCTAVES)) ?
                       COUNT_W'(MAX_OCTAVES) : octave_count_reg;

    // sequencer state
    state_t                 state_reg;
    logic [DIV_CNT_W-1:0]   div_cnt_reg;
    logic [COORD_W-1:0]     num_x_reg, num_z_reg;
    logic [SPAN_W-1:0]      rem_x_reg, rem_z_reg;
    logic [QUOT_W-1:0]      quo_x_reg, quo_z_reg;
    logic [OCT_W-1:0]       oct_reg;
    logic [AMP_W-1:0]       amp_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic                   m_tvalid_reg;
    logic [SUM_W-1:0]       m_sum_reg;

    // pipeline entry registers (one octave)
    logic                   p_valid_reg;
    logic [QCOORD_W-1:0]    p_qz_reg, p_qx_reg;
    logic [AMP_W-1:0]       p_amp_reg;

    logic pipe_busy;
    logic out_free;
    logic s_accept;
    logic out_load;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = (state_reg == ST_DRAIN) && !pipe_busy && out_free;

    // divider steps for both coordinates
    logic [SPAN_W+DIV_STEP-1:0] div_x_next, div_z_next;
    assign div_x_next = div_step3(rem_x_reg, num_x_reg[COORD_W-1 -: DIV_STEP], span_eff);
    assign div_z_next = div_step3(rem_z_reg, num_z_reg[COORD_W-1 -: DIV_STEP], span_eff);

    // octave window into the quotient and amplitude update
    logic [OCT_W-1:0]     win_shift;
    logic [2*AMP_W-1:0]   amp_prod;
    logic [AMP_W-1:0]     amp_next;
    logic                 last_oct;
    assign win_shift = OCT_W'(MAX_OCTAVES - 1) - oct_reg;
    assign amp_prod  = (2*AMP_W)'(amp_reg) * (2*AMP_W)'(amp_decay_reg);
    assign amp_next  = amp_prod[AMP_W+15:16];
    assign last_oct  = ({1'b0, oct_reg} == (count_eff - COUNT_W'(1)));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            p_valid_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            p_valid_reg <= (state_reg == ST_ISSUE);
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_cnt_reg == DIV_CNT_W'(DIV_CYCLES - 1)) begin
                        state_reg <= (count_eff == '0) ? ST_DRAIN : ST_ISSUE;
                    end
                end
                ST_ISSUE: begin
                    if (last_oct) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (out_load) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // sequencer datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                num_x_reg   <= s_tdata[COORD_W-1:0];
                num_z_reg   <= s_tdata[2*COORD_W-1:COORD_W];
                rem_x_reg   <= '0;
                rem_z_reg   <= '0;
                quo_x_reg   <= '0;
                quo_z_reg   <= '0;
                div_cnt_reg <= '0;
                oct_reg     <= '0;
                amp_reg     <= AMP_ONE;
            end
            ST_DIV: begin
                num_x_reg   <= num_x_reg << DIV_STEP;
                num_z_reg   <= num_z_reg << DIV_STEP;
                rem_x_reg   <= div_x_next[SPAN_W+DIV_STEP-1:DIV_STEP];
                rem_z_reg   <= div_z_next[SPAN_W+DIV_STEP-1:DIV_STEP];
                quo_x_reg   <= {quo_x_reg[QUOT_W-DIV_STEP-1:0], div_x_next[DIV_STEP-1:0]};
                quo_z_reg   <= {quo_z_reg[QUOT_W-DIV_STEP-1:0], div_z_next[DIV_STEP-1:0]};
                div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
            end
            ST_ISSUE: begin
                oct_reg <= oct_reg + OCT_W'(1);
                amp_reg <= amp_next;
            end
            default: ;
        endcase
        p_qz_reg  <= quo_z_reg[win_shift +: QCOORD_W];
        p_qx_reg  <= quo_x_reg[win_shift +: QCOORD_W];
        p_amp_reg <= amp_reg;
        if (out_load) begin
            m_sum_reg <= sum_reg;
        end
    end

    // ---------------- stage a: first hash level, squares, inner fade term
    logic                va_reg;
    logic [7:0]          a_ha_reg, a_hb_reg;
    logic [FRAC_W-1:0]   a_fa_reg, a_fb_reg, a_t2u_reg, a_t2v_reg;
    logic [20:0]         a_inu_reg, a_inv_reg;
    logic [AMP_W-1:0]    a_amp_reg;

    logic [7:0]          ca, cb;
    logic [FRAC_W-1:0]   fa, fb;
    logic [7:0]          a_ha_next, a_hb_next;
    logic [2*FRAC_W-1:0] sq_u, sq_v;
    assign ca = p_qz_reg[QCOORD_W-1:FRAC_W];
    assign cb = p_qx_reg[QCOORD_W-1:FRAC_W];
    assign fa = p_qz_reg[FRAC_W-1:0];
    assign fb = p_qx_reg[FRAC_W-1:0];
    assign a_ha_next = PERM_ROM[ca] + cb;
    assign a_hb_next = PERM_ROM[8'(ca + 8'd1)] + cb;
    assign sq_u = (2*FRAC_W)'(fa) * (2*FRAC_W)'(fa);
    assign sq_v = (2*FRAC_W)'(fb) * (2*FRAC_W)'(fb);

    // ---------------- stage b: second hash level, cubes
    logic                vb_reg;
    logic [7:0]          b_haa_reg, b_hab_reg, b_hba_reg, b_hbb_reg;
    logic [FRAC_W-1:0]   b_fa_reg, b_fb_reg, b_t3u_reg, b_t3v_reg;
    logic [20:0]         b_inu_reg, b_inv_reg;
    logic [AMP_W-1:0]    b_amp_reg;

    logic [2*FRAC_W-1:0] cu_u, cu_v;
    assign cu_u = (2*FRAC_W)'(a_t2u_reg) * (2*FRAC_W)'(a_fa_reg);
    assign cu_v = (2*FRAC_W)'(a_t2v_reg) * (2*FRAC_W)'(a_fb_reg);

    // ---------------- stage c: fade result, corner gradients
    logic                vc_reg;
    logic [16:0]         c_u_reg, c_v_reg;
    logic signed [18:0]  c_g00_reg, c_g10_reg, c_g01_reg, c_g11_reg;
    logic [AMP_W-1:0]    c_amp_reg;

    logic [36:0]         fu_prod, fv_prod;
    logic signed [17:0]  px0, px1, py0, py1;
    assign fu_prod = 37'(b_t3u_reg) * 37'(b_inu_reg);
    assign fv_prod = 37'(b_t3v_reg) * 37'(b_inv_reg);
    assign px0 = $signed({2'b00, b_fa_reg});
    assign py0 = $signed({2'b00, b_fb_reg});
    assign px1 = px0 - 18'sd65536;
    assign py1 = py0 - 18'sd65536;

    // ---------------- stage d: lerp along the first axis
    logic                vd_reg;
    logic signed [19:0]  d_l0_reg, d_l1_reg;
    logic [16:0]         d_v_reg;
    logic [AMP_W-1:0]    d_amp_reg;

    logic signed [19:0]  d_df0, d_df1;
    logic signed [37:0]  d_pr0, d_pr1;
    assign d_df0 = 20'(c_g10_reg) - 20'(c_g00_reg);
    assign d_df1 = 20'(c_g11_reg) - 20'(c_g01_reg);
    assign d_pr0 = 38'($signed({1'b0, c_u_reg})) * 38'(d_df0);
    assign d_pr1 = 38'($signed({1'b0, c_u_reg})) * 38'(d_df1);

    // ---------------- stage e: lerp along the second axis
    logic                ve_reg;
    logic signed [20:0]  e_n_reg;
    logic [AMP_W-1:0]    e_amp_reg;

    logic signed [20:0]  e_df;
    logic signed [38:0]  e_pr;
    assign e_df = 21'(d_l1_reg) - 21'(d_l0_reg);
    assign e_pr = 39'($signed({1'b0, d_v_reg})) * 39'(e_df);

    // ---------------- stage f: map to 0..255 in Q.8
    logic                vf_reg;
    logic [15:0]         f_map_reg;
    logic [AMP_W-1:0]    f_amp_reg;

    logic signed [21:0]  f_n1;
    logic [25:0]         f_scaled;
    logic [16:0]         f_map_raw;
    logic [15:0]         f_map_next;
    assign f_n1      = 22'(e_n_reg) + 22'sd65536;
    assign f_scaled  = f_n1[21] ? 26'd0 : (26'(f_n1[17:0]) * 26'd255);
    assign f_map_raw = f_scaled[25:9];
    assign f_map_next = (f_map_raw > 17'(MAP_MAX)) ? MAP_MAX : f_map_raw[15:0];

    // ---------------- stage g: amplitude weight
    logic                vg_reg;
    logic [16:0]         g_term_reg;

    logic [32:0]         g_prod;
    assign g_prod = 33'(f_map_reg) * 33'(f_amp_reg);

    // accumulation with saturation
    logic [SUM_W:0]      sum_wide;
    assign sum_wide = (SUM_W+1)'(sum_reg) + (SUM_W+1)'(g_term_reg);

    assign pipe_busy = p_valid_reg | va_reg | vb_reg | vc_reg | vd_reg | ve_reg
                     | vf_reg | vg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
            vf_reg <= 1'b0;
            vg_reg <= 1'b0;
        end else begin
            va_reg <= p_valid_reg;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
            ve_reg <= vd_reg;
            vf_reg <= ve_reg;
            vg_reg <= vf_reg;
        end
    end

    always_ff @(posedge aclk) begin
        // stage a
        a_ha_reg  <= a_ha_next;
        a_hb_reg  <= a_hb_next;
        a_fa_reg  <= fa;
        a_fb_reg  <= fb;
        a_t2u_reg <= sq_u[2*FRAC_W-1:FRAC_W];
        a_t2v_reg <= sq_v[2*FRAC_W-1:FRAC_W];
        a_inu_reg <= fade_inner(fa);
        a_inv_reg <= fade_inner(fb);
        a_amp_reg <= p_amp_reg;
        // stage b
        b_haa_reg <= PERM_ROM[a_ha_reg];
        b_hab_reg <= PERM_ROM[8'(a_ha_reg + 8'd1)];
        b_hba_reg <= PERM_ROM[a_hb_reg];
        b_hbb_reg <= PERM_ROM[8'(a_hb_reg + 8'd1)];
        b_fa_reg  <= a_fa_reg;
        b_fb_reg  <= a_fb_reg;
        b_t3u_reg <= cu_u[2*FRAC_W-1:FRAC_W];
        b_t3v_reg <= cu_v[2*FRAC_W-1:FRAC_W];
        b_inu_reg <= a_inu_reg;
        b_inv_reg <= a_inv_reg;
        b_amp_reg <= a_amp_reg;
        // stage c
        c_u_reg   <= fu_prod[32:16];
        c_v_reg   <= fv_prod[32:16];
        c_g00_reg <= grad(PERM_ROM[b_haa_reg][3:0], px0, py0);
        c_g10_reg <= grad(PERM_ROM[b_hba_reg][3:0], px1, py0);
        c_g01_reg <= grad(PERM_ROM[b_hab_reg][3:0], px0, py1);
        c_g11_reg <= grad(PERM_ROM[b_hbb_reg][3:0], px1, py1);
        c_amp_reg <= b_amp_reg;
        // stage d
        d_l0_reg  <= 20'(c_g00_reg) + 20'(d_pr0 >>> FRAC_W);
        d_l1_reg  <= 20'(c_g01_reg) + 20'(d_pr1 >>> FRAC_W);
        d_v_reg   <= c_v_reg;
        d_amp_reg <= c_amp_reg;
        // stage e
        e_n_reg   <= 21'(d_l0_reg) + 21'(e_pr >>> FRAC_W);
        e_amp_reg <= d_amp_reg;
        // stage f
        f_map_reg <= f_map_next;
        f_amp_reg <= e_amp_reg;
        // stage g
        g_term_reg <= g_prod[32:16];
    end

    // running sum, cleared when an item is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else if (s_accept) begin
            sum_reg <= '0;
        end else if (vg_reg) begin
            sum_reg <= (sum_wide > (SUM_W+1)'(SUM_MAX)) ? SUM_MAX : sum_wide[SUM_W-1:0];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'd0, m_sum_reg};

    // no octave in flight while a new item can be taken
    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !pipe_busy)
        else $error("noise pipeline busy while idle");

    // running sum stays within the output range
    a_sum_range: assert property (@(posedge aclk) disable iff (!aresetn)
        sum_reg <= SUM_MAX)
        else $error("running sum above saturation limit");

    // a result is loaded only after the last octave has been summed
    a_load_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> !vg_reg && !p_valid_reg)
        else $error("result loaded with octaves in flight");

    // octaves enter the pipeline only while issuing
    a_issue_state: assert property (@(posedge aclk) disable iff (!aresetn)
        p_valid_reg |-> $past(state_reg) == ST_ISSUE)
        else $error("octave issued outside issue phase");

endmodule

// File: dv/fpn_scoreboard.sv
// result checker for fractal_perlin_noise: watches config writes and both streams,
// predicts each noise_sum from its own fixed-point fbm model and compares in order
// depends on fpn_pkg (permutation rom, register indexes, reset values)
module fpn_scoreboard
    import fpn_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    output int          fail_count,
    output int          sums_pending
);

    logic [4:0]  octaves;
    logic [15:0] span;
    logic [15:0] decay;
    logic [19:0] sum_queue[$];

    assign sums_pending = sum_queue.size();

    function automatic longint fshift(longint v);
        return v >>> INNER_FRAC_BITS;
    endfunction

    function automatic longint fade_q(longint t);
        longint t2, t3, inr;
        t2  = fshift(t * t);
        t3  = fshift(t2 * t);
        inr = fshift(t * (6 * t - 15 * 65536)) + 10 * 65536;
        return fshift(t3 * inr);
    endfunction

    function automatic longint blend(longint t, longint a, longint b);
        return a + fshift(t * (b - a));
    endfunction

    function automatic longint slope(int unsigned hin, longint px, longint py);
        int unsigned h;
        longint u, v;
        h = hin & 15;
        u = (h < 8) ? px : py;
        v = (h < 4) ? py : ((h == 12 || h == 14) ? px : 0);
        return ((h & 1) ? -u : u) + ((h & 2) ? -v : v);
    endfunction

    // floor(c * 2^s / d) wrapped to 24 bits, one bit per step
    function automatic longint unsigned grid_pos(longint unsigned c, int s,
                                                 longint unsigned d);
        longint unsigned q, r;
        q = (c / d) & 24'hFFFFFF;
        r = c % d;
        for (int i = 0; i < s; i++) begin
            r = r << 1;
            q = (q << 1) & 24'hFFFFFF;
            if (r >= d) begin
                r = r - d;
                q = q | 1;
            end
        end
        return q;
    endfunction

    function automatic longint slice_noise(longint unsigned qa, longint unsigned qb);
        int unsigned ca, cb, ha, hb, haa, hab, hba, hbb;
        longint fa, fb, u, v, l0, l1;
        ca  = 32'((qa >> 16) & 255);
        cb  = 32'((qb >> 16) & 255);
        fa  = qa & 16'hFFFF;
        fb  = qb & 16'hFFFF;
        u   = fade_q(fa);
        v   = fade_q(fb);
        ha  = (PERM_ROM[ca] + cb) & 255;
        hb  = (PERM_ROM[(ca + 1) & 255] + cb) & 255;
        haa = PERM_ROM[ha];
        hab = PERM_ROM[(ha + 1) & 255];
        hba = PERM_ROM[hb];
        hbb = PERM_ROM[(hb + 1) & 255];
        l0  = blend(u, slope(PERM_ROM[haa], fa, fb),
                       slope(PERM_ROM[hba], fa - 65536, fb));
        l1  = blend(u, slope(PERM_ROM[hab], fa, fb - 65536),
                       slope(PERM_ROM[hbb], fa - 65536, fb - 65536));
        return blend(v, l0, l1);
    endfunction

    function automatic logic [19:0] fbm_sum(logic [23:0] xc, logic [23:0] zc);
        longint unsigned d, amp, sum, mapped;
        longint n;
        int cnt;
        d   = ((span == 0) ? 64'd1 : 64'(span)) << COORD_FRAC_BITS;
        cnt = (octaves > MAX_OCTAVES) ? MAX_OCTAVES : int'(octaves);
        amp = 65536;
        sum = 0;
        for (int o = 0; o < cnt; o++) begin
            n = slice_noise(grid_pos(zc, o + 17, d), grid_pos(xc, o + 17, d)) + 65536;
            if (n < 0) n = 0;
            mapped = (longint'(n) * 255) >> 9;
            if (mapped > 65280) mapped = 65280;
            sum += (mapped * amp) >> 16;
            if (sum > 1044480) sum = 1044480;
            amp = (amp * decay) >> 16;
        end
        return sum[19:0];
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            octaves    = OCTAVE_COUNT_RST;
            span       = GRID_SPAN_RST;
            decay      = AMP_DECAY_RST;
            fail_count = 0;
            sum_queue.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_OCTAVE_COUNT: octaves = cfg_wdata[4:0];
                    CFG_GRID_SPAN:    span    = cfg_wdata;
                    CFG_AMP_DECAY:    decay   = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                sum_queue.insert(sum_queue.size(),
                                 fbm_sum(s_tdata[23:0], s_tdata[47:24]));
            if (m_tvalid && m_tready) begin
                if (sum_queue.size() == 0) begin
                    $error("unexpected item: noise_sum actual %0d", m_tdata[19:0]);
                    fail_count++;
                end else begin
                    logic [19:0] want;
                    want = sum_queue.pop_front();
                    if (m_tdata[19:0] !== want) begin
                        $error("noise_sum expected %0d actual %0d", want, m_tdata[19:0]);
                        fail_count++;
                    end
                    if (m_tdata[23:20] !== 4'd0) begin
                        $error("pad expected 0 actual %0d", m_tdata[23:20]);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

// File: dv/fractal_perlin_noise_tb.sv
// top of the fractal_perlin_noise bench: clock, reset, stimulus, receiver stalls, verdict
// depends on fpn_pkg, fractal_perlin_noise and fpn_scoreboard
module fractal_perlin_noise_tb
    import fpn_pkg::*;
();

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;     // [23:0] x_coord, [47:24] z_coord
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;     // [19:0] noise_sum, [23:20] zero
    int          fail_count;
    int          sums_pending;
    logic        hold_req;    // asks the receiver for one long hold-off

    fractal_perlin_noise dut (.*);

    fpn_scoreboard u_check (.*);

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #4000000;
        $display("fractal_perlin_noise_tb failed");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // receiver: random stalls, plus one long counted hold-off on request
    initial begin
        int stall_left;
        int r;
        bit held;
        stall_left = 0;
        held       = 1'b0;
        m_tready   = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req && !held) begin
                stall_left = 1500;
                held       = 1'b1;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                r = $urandom_range(99);
                if (r < 60) begin
                    m_tready <= 1'b1;
                end else begin
                    stall_left = pick_gap();
                    m_tready <= (stall_left == 0);
                end
            end
        end
    end

    task automatic reg_write(logic [1:0] idx, logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // offer one item and hold it until accepted, then maybe leave a gap
    task automatic send_item(logic [23:0] xc, logic [23:0] zc, bit gaps);
        int g;
        s_tvalid <= 1'b1;
        s_tdata  <= {zc, xc};
        do @(posedge aclk); while (!s_tready);
        g = gaps ? pick_gap() : 0;
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g - 1) @(posedge aclk);
        end
    endtask

    // all results in, block back at rest, input lowered
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sums_pending != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    function automatic logic [23:0] rand_coord();
        case ($urandom_range(3))
            0:       return 24'($urandom());
            1:       return 24'($urandom_range(4095));
            2:       return 24'hFFFFFF - 24'($urandom_range(255));
            default: return 24'($urandom_range(255)) << $urandom_range(16);
        endcase
    endfunction

    function automatic logic [15:0] rand_span();
        case ($urandom_range(4))
            0:       return 16'($urandom_range(2));
            1:       return 16'hFFFF;
            2:       return 16'($urandom());
            default: return 16'($urandom_range(512));
        endcase
    endfunction

    function automatic logic [15:0] rand_decay();
        case ($urandom_range(3))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            default: return 16'($urandom());
        endcase
    endfunction

    initial begin
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_OCTAVE_COUNT;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        hold_req  = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: corners of the coordinate range and one inner point
        send_item(24'h000000, 24'h000000, 0);
        send_item(24'hFFFFFF, 24'hFFFFFF, 0);
        send_item(24'hFFFFFF, 24'h000000, 1);
        send_item(24'h000000, 24'hFFFFFF, 1);
        send_item(24'h012345, 24'h00C800, 1);
        drain();

        // zero octaves gives zero
        reg_write(CFG_OCTAVE_COUNT, 16'd0);
        send_item(24'h123456, 24'h654321, 0);
        send_item(24'hFFFFFF, 24'hFFFFFF, 0);
        drain();

        // octave count above the maximum, zero span acting as one, no decay
        reg_write(CFG_OCTAVE_COUNT, 16'd31);
        reg_write(CFG_GRID_SPAN, 16'd0);
        reg_write(CFG_AMP_DECAY, 16'hFFFF);
        send_item(24'h000080, 24'h000040, 0);
        send_item(24'hABCDEF, 24'h13579B, 0);
        send_item(24'hFFFFFF, 24'hFFFFFF, 0);
        drain();

        // full persistence, sixteen and seventeen octaves: saturation territory
        reg_write(CFG_GRID_SPAN, 16'hFFFF);
        reg_write(CFG_OCTAVE_COUNT, 16'd16);
        send_item(24'hFFFFFF, 24'h7FFFFF, 0);
        send_item(24'h000001, 24'h000001, 0);
        drain();
        reg_write(CFG_OCTAVE_COUNT, 16'd17);
        send_item(24'h800000, 24'h800000, 0);
        drain();

        // zero decay keeps only the first octave; index three is ignored
        reg_write(CFG_AMP_DECAY, 16'd0);
        reg_write(CFG_GRID_SPAN, 16'd1);
        reg_write(2'd3, 16'hFFFF);
        reg_write(CFG_OCTAVE_COUNT, 16'd1);
        send_item(24'h00017F, 24'h000280, 0);
        send_item(24'hFFFF00, 24'h0000FF, 0);
        drain();

        // long receiver hold-off while items keep coming
        hold_req <= 1'b1;
        for (int i = 0; i < 6; i++) send_item(rand_coord(), rand_coord(), 0);
        hold_req <= 1'b0;
        drain();

        // random phases with random settings
        for (int ph = 0; ph < 13; ph++) begin
            reg_write(CFG_OCTAVE_COUNT, 16'($urandom_range(31)));
            reg_write(CFG_GRID_SPAN, rand_span());
            reg_write(CFG_AMP_DECAY, rand_decay());
            if ($urandom_range(3) == 0) reg_write(2'd3, 16'($urandom()));
            for (int i = 0; i < 50; i++) send_item(rand_coord(), rand_coord(), ph % 4 != 3);
            drain();
        end

        if (fail_count == 0) begin
            $display("fractal_perlin_noise_tb passed");
        end else begin
            $display("fractal_perlin_noise_tb failed");
        end
        $finish;
    end

endmodule

// File: files.f
sv/fpn_pkg.sv
sv/fractal_perlin_noise.sv
dv/fpn_scoreboard.sv
dv/fractal_perlin_noise_tb.sv
